@@ sv/fall_vote_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// fall_vote_tracker assertion macros
// Shorthands for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FALL_VOTE_TRACKER_MACROS_SVH
`define FALL_VOTE_TRACKER_MACROS_SVH

// same-cycle implication
`define FVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FVT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fvt_pkg.sv @@
// ----------------------------------------------------------------------------
// fvt_pkg
// Types and constants shared by the fall vote tracker modules.
// ----------------------------------------------------------------------------
package fvt_pkg;

    localparam int COORD_BITS     = 12;
    localparam int CENTER_W       = COORD_BITS + 1;
    localparam int DIST_W         = 27;
    localparam int IDENT_W        = 16;
    localparam int VOTE_W         = 4;
    localparam int LOST_W         = 6;
    localparam int CONF_W         = 8;
    localparam int ASPECT_W       = 10;
    localparam int KPC_W          = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 27;
    localparam int MAX_TRACKS_DEF = 16;

    localparam logic [LOST_W-1:0]  LOST_SAT        = '1;
    localparam logic [KPC_W-1:0]   POSE_MIN_POINTS = 5'd13;
    localparam logic [IDENT_W-1:0] IDENT_RST       = 16'd1;

    localparam logic [DIST_W-1:0]   MATCH_DIST_RST = 27'd671089;
    localparam logic [CONF_W-1:0]   CONF_MIN_RST   = 8'd51;
    localparam logic [ASPECT_W-1:0] ASPECT_RST     = 10'd269;
    localparam logic [VOTE_W-1:0]   VOTE_MAX_RST   = 4'd8;
    localparam logic [VOTE_W-1:0]   FALL_VOTES_RST = 4'd4;
    localparam logic [VOTE_W-1:0]   SUSP_VOTES_RST = 4'd2;
    localparam logic [LOST_W-1:0]   LOST_LIMIT_RST = 6'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_DIST_SQ = 3'd0,
        CFG_CONF_MIN      = 3'd1,
        CFG_ASPECT_Q8     = 3'd2,
        CFG_VOTE_MAX      = 3'd3,
        CFG_FALL_VOTES    = 3'd4,
        CFG_SUSPECT_VOTES = 3'd5,
        CFG_LOST_LIMIT    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FS_STANDING = 2'd0,
        FS_FALLING  = 2'd1,
        FS_FALLEN   = 2'd2
    } t_fall_state;

    typedef enum logic {
        MODE_FRAME  = 1'b0,
        MODE_DETECT = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST1,
        ST_DIST2,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_w;
        logic [11:0] box_h;
        logic [4:0]  keypoint_count;
        logic [47:0] shoulder_points;
        logic [47:0] hip_points;
        logic [31:0] keypoint_confs;
    } t_track_in;

    typedef struct packed {
        logic [15:0] track_number;
        logic [1:0]  fall_state;
        logic        opened_track;
        logic        table_full;
    } t_track_out;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                age;
        logic [LOST_W-1:0]   lost_limit;
        logic [DIST_W-1:0]   match_dist_sq;
        logic [CENTER_W-1:0] det_cx;
        logic [CENTER_W-1:0] det_cy;
        logic                wr_open;
        logic [IDENT_W-1:0]  wr_ident;
        logic [VOTE_W-1:0]   wr_votes;
    } t_cell_cmd;

    // search token passed cell to cell
    typedef struct packed {
        logic               found;
        logic [DIST_W-1:0]  best_d;
        logic [IDENT_W-1:0] ident;
        logic [VOTE_W-1:0]  votes;
        logic               free_found;
    } t_scan_tok;

    function automatic logic [CENTER_W-1:0] abs_diff(input logic [CENTER_W-1:0] a,
                                                      input logic [CENTER_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

@@ sv/fall_vote_tracker.sv @@
// ----------------------------------------------------------------------------
// fall_vote_tracker
// Person track table with per-track fall voting.
// ----------------------------------------------------------------------------
// A frame-start transaction prunes and ages all tracks and gives no result.
// A detection passes the distance registers inside the slot cells (the
// coordinate differences, then the squared distance), then the search token
// walks the cell chain one cell per cycle, then the update state writes the
// chosen slot and the result. The next transaction is taken only in the idle
// state after the update; a stalled result holds the update state and the
// input. The input is ready only between transactions; a finished result
// waits in the output register while the next transaction is taken.
module fall_vote_tracker import fvt_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_track_in             i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_track_out            o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_TRACKS);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cnt;
    t_track_in           r_in;
    logic [CENTER_W-1:0] r_cx, r_cy;
    logic                r_horiz;
    logic [IDENT_W-1:0]  r_next_ident;
    logic                r_out_valid;
    t_track_out          r_out, n_out;

    logic [DIST_W-1:0]   r_match_dist_sq;
    logic [CONF_W-1:0]   r_conf_min;
    logic [ASPECT_W-1:0] r_aspect_q8;
    logic [VOTE_W-1:0]   r_vote_max, r_fall_votes, r_suspect_votes;
    logic [LOST_W-1:0]   r_lost_limit;

    t_cell_cmd           cmd;
    t_scan_tok           tok      [MAX_TRACKS+1];
    logic [IDX_W-1:0]    best_idx [MAX_TRACKS+1];
    logic [IDX_W-1:0]    free_idx [MAX_TRACKS+1];
    t_scan_tok           fin;

    logic                in_acc, out_free, upd, wr_en, age;
    logic [IDX_W-1:0]    wr_idx;
    logic [VOTE_W-1:0]   base, vote;
    logic [VOTE_W:0]     vote_t;
    logic                horiz_c, pose_ok;
    logic [CENTER_W-1:0] sx, sy, hx, hy;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign fin      = tok[MAX_TRACKS];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_dist_sq <= MATCH_DIST_RST;
            r_conf_min      <= CONF_MIN_RST;
            r_aspect_q8     <= ASPECT_RST;
            r_vote_max      <= VOTE_MAX_RST;
            r_fall_votes    <= FALL_VOTES_RST;
            r_suspect_votes <= SUSP_VOTES_RST;
            r_lost_limit    <= LOST_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MATCH_DIST_SQ: r_match_dist_sq <= i_cfg_wr_data[DIST_W-1:0];
                CFG_CONF_MIN:      r_conf_min      <= i_cfg_wr_data[CONF_W-1:0];
                CFG_ASPECT_Q8:     r_aspect_q8     <= i_cfg_wr_data[ASPECT_W-1:0];
                CFG_VOTE_MAX:      r_vote_max      <= i_cfg_wr_data[VOTE_W-1:0];
                CFG_FALL_VOTES:    r_fall_votes    <= i_cfg_wr_data[VOTE_W-1:0];
                CFG_SUSPECT_VOTES: r_suspect_votes <= i_cfg_wr_data[VOTE_W-1:0];
                CFG_LOST_LIMIT:    r_lost_limit    <= i_cfg_wr_data[LOST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- posture test ----------------
    always_comb begin
        sx = CENTER_W'(r_in.shoulder_points[11:0]) + CENTER_W'(r_in.shoulder_points[35:24]);
        sy = CENTER_W'(r_in.shoulder_points[23:12]) + CENTER_W'(r_in.shoulder_points[47:36]);
        hx = CENTER_W'(r_in.hip_points[11:0]) + CENTER_W'(r_in.hip_points[35:24]);
        hy = CENTER_W'(r_in.hip_points[23:12]) + CENTER_W'(r_in.hip_points[47:36]);
        pose_ok = (r_in.keypoint_count >= POSE_MIN_POINTS) &&
                  (r_in.keypoint_confs[7:0]   > r_conf_min) &&
                  (r_in.keypoint_confs[15:8]  > r_conf_min) &&
                  (r_in.keypoint_confs[23:16] > r_conf_min) &&
                  (r_in.keypoint_confs[31:24] > r_conf_min);
        if (pose_ok) begin
            horiz_c = abs_diff(hx, sx) > abs_diff(hy, sy);
        end else begin
            horiz_c = {2'b00, r_in.box_w, 8'd0} > (22'(r_in.box_h) * 22'(r_aspect_q8));
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc && (i_in.mode == MODE_DETECT)) n_state = ST_DIST1;
            ST_DIST1:  n_state = ST_DIST2;
            ST_DIST2:  n_state = ST_SCAN;
            ST_SCAN:   if (r_cnt == IDX_W'(MAX_TRACKS - 1)) n_state = ST_UPDATE;
            ST_UPDATE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        age        = 1'b0;
        upd        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                age        = i_in_valid && (i_in.mode == MODE_FRAME);
            end
            ST_UPDATE: upd = out_free;
            default: ;
        endcase
    end

    // ---------------- update datapath ----------------
    always_comb begin
        wr_en  = upd && (fin.found || fin.free_found);
        wr_idx = fin.found ? best_idx[MAX_TRACKS] : free_idx[MAX_TRACKS];
        base   = fin.found ? fin.votes : '0;
        if (r_horiz) begin
            vote_t = {1'b0, base} + 1'b1;
        end else begin
            vote_t = (base == '0) ? '0 : {1'b0, base} - 1'b1;
        end
        vote = (vote_t > {1'b0, r_vote_max}) ? r_vote_max : vote_t[VOTE_W-1:0];

        n_out = '0;
        if (!fin.found && !fin.free_found) begin
            n_out.table_full = 1'b1;
        end else begin
            n_out.track_number = fin.found ? fin.ident : r_next_ident;
            n_out.opened_track = !fin.found;
            if (vote >= r_fall_votes) begin
                n_out.fall_state = FS_FALLEN;
            end else if (vote >= r_suspect_votes) begin
                n_out.fall_state = FS_FALLING;
            end else begin
                n_out.fall_state = FS_STANDING;
            end
        end

        cmd.age           = age;
        cmd.lost_limit    = r_lost_limit;
        cmd.match_dist_sq = r_match_dist_sq;
        cmd.det_cx        = r_cx;
        cmd.det_cy        = r_cy;
        cmd.wr_open       = !fin.found;
        cmd.wr_ident      = r_next_ident;
        cmd.wr_votes      = vote;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_next_ident <= IDENT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == ST_SCAN) ? r_cnt + 1'b1 : '0;
            if (upd && !fin.found && fin.free_found) begin
                r_next_ident <= r_next_ident + 1'b1;
            end
            if (upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
            r_cx <= CENTER_W'(i_in.box_x) + CENTER_W'(i_in.box_w[11:1]);
            r_cy <= CENTER_W'(i_in.box_y) + CENTER_W'(i_in.box_h[11:1]);
        end
        r_horiz <= horiz_c;
        if (upd) begin
            r_out <= n_out;
        end
    end

    // ---------------- cell chain ----------------
    assign tok[0]      = '0;
    assign best_idx[0] = '0;
    assign free_idx[0] = '0;

    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        fvt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_wr_sel   (wr_en && (wr_idx == IDX_W'(g))),
            .i_tok      (tok[g]),
            .i_best_idx (best_idx[g]),
            .i_free_idx (free_idx[g]),
            .o_tok      (tok[g+1]),
            .o_best_idx (best_idx[g+1]),
            .o_free_idx (free_idx[g+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/fvt_cell.sv @@
// ----------------------------------------------------------------------------
// fvt_cell
// One track slot: holds its state, measures distance to the current
// detection and merges itself into the search token from its left neighbor.
// ----------------------------------------------------------------------------
module fvt_cell import fvt_pkg::*; #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic             i_wr_sel,
    input  t_scan_tok        i_tok,
    input  logic [IDX_W-1:0] i_best_idx,
    input  logic [IDX_W-1:0] i_free_idx,
    output t_scan_tok        o_tok,
    output logic [IDX_W-1:0] o_best_idx,
    output logic [IDX_W-1:0] o_free_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                r_valid;
    logic [IDENT_W-1:0]  r_ident;
    logic [CENTER_W-1:0] r_cx, r_cy, r_dx, r_dy;
    logic [VOTE_W-1:0]   r_votes;
    logic [LOST_W-1:0]   r_lost;
    logic [DIST_W-1:0]   r_d;
    t_scan_tok           r_tok, n_tok;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx, r_free_idx, n_free_idx;
    logic                hit, take;
    logic [DIST_W-1:0]   dx_w, dy_w;

    assign hit  = r_valid && (r_d < i_cmd.match_dist_sq);
    assign take = hit && (!i_tok.found || (r_d < i_tok.best_d) ||
                  ((r_d == i_tok.best_d) && (r_ident < i_tok.ident)));

    // squares need the full distance width
    assign dx_w = DIST_W'(r_dx);
    assign dy_w = DIST_W'(r_dy);

    always_comb begin
        n_tok      = i_tok;
        n_best_idx = i_best_idx;
        n_free_idx = i_free_idx;
        if (take) begin
            n_tok.found  = 1'b1;
            n_tok.best_d = r_d;
            n_tok.ident  = r_ident;
            n_tok.votes  = r_votes;
            n_best_idx   = MY_IDX;
        end
        if (!i_tok.free_found && !r_valid) begin
            n_tok.free_found = 1'b1;
            n_free_idx       = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.age && r_valid) begin
                if (r_lost > i_cmd.lost_limit) begin
                    r_valid <= 1'b0;
                end else if (r_lost != LOST_SAT) begin
                    r_lost <= r_lost + 1'b1;
                end
            end
            if (i_wr_sel) begin
                r_valid <= 1'b1;
                if (i_cmd.wr_open) begin
                    r_ident <= i_cmd.wr_ident;
                end
                r_cx    <= i_cmd.det_cx;
                r_cy    <= i_cmd.det_cy;
                r_lost  <= '0;
                r_votes <= i_cmd.wr_votes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx <= n_best_idx;
        r_free_idx <= n_free_idx;
        r_dx       <= abs_diff(i_cmd.det_cx, r_cx);
        r_dy       <= abs_diff(i_cmd.det_cy, r_cy);
        r_d        <= (dx_w * dx_w) + (dy_w * dy_w);
    end

    assign o_tok      = r_tok;
    assign o_best_idx = r_best_idx;
    assign o_free_idx = r_free_idx;

endmodule

@@ sv/fvt_checker.sv @@
// ----------------------------------------------------------------------------
// fvt_checker
// Port-level assertions for fall_vote_tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "fall_vote_tracker_macros.svh"

module fvt_checker import fvt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_track_in  i_in,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_track_out o_out
);

    logic acc_frame, acc_det, full_dirty;

    assign acc_frame  = i_in_valid && o_in_ready && (i_in.mode == MODE_FRAME);
    assign acc_det    = i_in_valid && o_in_ready && (i_in.mode == MODE_DETECT);
    assign full_dirty = (o_out.track_number != '0) || o_out.opened_track;

    `FVT_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `FVT_ASSERT_IMP(a_full_clean, o_out_valid && o_out.table_full, !full_dirty, "dirty full")
    `FVT_ASSERT_NXT(a_frame_fast, acc_frame, o_in_ready, "frame start not single cycle")
    `FVT_ASSERT_NXT(a_det_busy, acc_det, !o_in_ready, "detection did not occupy block")

endmodule

bind fall_vote_tracker fvt_checker u_fvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

@@ test/tb_fall_vote_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fall_vote_tracker
// Self-checking bench for the fall vote tracker. A behavioral track table
// predicts each detection result; directed corner cases are followed by
// randomized frames of clustered detections under several register settings,
// with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_fall_vote_tracker;
    import fvt_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1500000;

    // ------------------------------------------------------------------------
    // track table predictor and result queue
    class track_scoreboard;
        logic [26:0] dist_lim;
        logic [7:0]  conf_min;
        logic [9:0]  aspect;
        logic [3:0]  vote_max, fall_votes, susp_votes;
        logic [5:0]  lost_limit;
        bit          live[NSLOT];
        logic [15:0] ident[NSLOT];
        logic [12:0] cx[NSLOT], cy[NSLOT];
        logic [3:0]  votes[NSLOT];
        logic [5:0]  lost[NSLOT];
        logic [15:0] next_ident;
        t_track_out  pending[$];
        int          errors, results, opened, full_hits;

        function new();
            dist_lim = MATCH_DIST_RST; conf_min = CONF_MIN_RST; aspect = ASPECT_RST;
            vote_max = VOTE_MAX_RST; fall_votes = FALL_VOTES_RST;
            susp_votes = SUSP_VOTES_RST; lost_limit = LOST_LIMIT_RST;
            foreach (live[i]) begin
                live[i] = 0; ident[i] = 0; cx[i] = 0; cy[i] = 0; votes[i] = 0; lost[i] = 0;
            end
            next_ident = IDENT_RST;
            errors = 0; results = 0; opened = 0; full_hits = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [26:0] v);
            case (idx)
                CFG_MATCH_DIST_SQ: dist_lim = v;
                CFG_CONF_MIN:      conf_min = v[7:0];
                CFG_ASPECT_Q8:     aspect = v[9:0];
                CFG_VOTE_MAX:      vote_max = v[3:0];
                CFG_FALL_VOTES:    fall_votes = v[3:0];
                CFG_SUSPECT_VOTES: susp_votes = v[3:0];
                CFG_LOST_LIMIT:    lost_limit = v[5:0];
                default: ;
            endcase
        endfunction

        function void expect_result(t_track_out r);
            pending = {pending, r};
        endfunction

        function bit lying_down(t_track_in t);
            bit h;
            logic [12:0] sx, sy, hx, hy, ax, ay;
            h = ({12'd0, t.box_w} * 24'd256) > ({12'd0, t.box_h} * {14'd0, aspect});
            if (t.keypoint_count >= POSE_MIN_POINTS && t.keypoint_confs[7:0] > conf_min &&
                t.keypoint_confs[15:8] > conf_min && t.keypoint_confs[23:16] > conf_min &&
                t.keypoint_confs[31:24] > conf_min) begin
                sx = t.shoulder_points[11:0] + t.shoulder_points[35:24];
                sy = t.shoulder_points[23:12] + t.shoulder_points[47:36];
                hx = t.hip_points[11:0] + t.hip_points[35:24];
                hy = t.hip_points[23:12] + t.hip_points[47:36];
                ax = hx > sx ? hx - sx : sx - hx;
                ay = hy > sy ? hy - sy : sy - hy;
                h = ax > ay;
            end
            return h;
        endfunction

        function void note_input(t_track_in t);
            int best, slot, v;
            logic [26:0] best_d, d;
            logic [12:0] ux, uy, dx, dy;
            t_track_out r;
            if (t.mode == MODE_FRAME) begin
                foreach (live[i]) if (live[i]) begin
                    if (lost[i] > lost_limit) live[i] = 0;
                    else if (lost[i] != LOST_SAT) lost[i]++;
                end
                return;
            end
            ux = t.box_x + (t.box_w >> 1);
            uy = t.box_y + (t.box_h >> 1);
            best = -1; best_d = 0; slot = -1;
            foreach (live[i]) if (live[i]) begin
                dx = ux > cx[i] ? ux - cx[i] : cx[i] - ux;
                dy = uy > cy[i] ? uy - cy[i] : cy[i] - uy;
                d = dx * dx + dy * dy;
                if (d < dist_lim && (best < 0 || d < best_d ||
                    (d == best_d && ident[i] < ident[best]))) begin
                    best = i; best_d = d;
                end
            end
            r = '0;
            if (best < 0) begin
                foreach (live[i]) if (!live[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    r.table_full = 1;
                    expect_result(r);
                    full_hits++;
                    return;
                end
                live[slot] = 1; ident[slot] = next_ident; votes[slot] = 0;
                next_ident++;
                best = slot; r.opened_track = 1; opened++;
            end
            cx[best] = ux; cy[best] = uy; lost[best] = 0;
            v = votes[best] + (lying_down(t) ? 1 : -1);
            if (v < 0) v = 0;
            if (v > vote_max) v = vote_max;
            votes[best] = 4'(v);
            r.track_number = ident[best];
            r.fall_state = (v >= fall_votes) ? FS_FALLEN :
                           (v >= susp_votes) ? FS_FALLING : FS_STANDING;
            expect_result(r);
        endfunction

        function void check_result(t_track_out got);
            t_track_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            results++;
            if (got.track_number !== exp_r.track_number)
                $display("%0t: track_number exp %0d got %0d", $time,
                         exp_r.track_number, got.track_number);
            if (got.fall_state !== exp_r.fall_state)
                $display("%0t: fall_state exp %0d got %0d", $time,
                         exp_r.fall_state, got.fall_state);
            if (got.opened_track !== exp_r.opened_track)
                $display("%0t: opened_track exp %0b got %0b", $time,
                         exp_r.opened_track, got.opened_track);
            if (got.table_full !== exp_r.table_full)
                $display("%0t: table_full exp %0b got %0b", $time,
                         exp_r.table_full, got.table_full);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    t_track_in   i_in;
    t_track_out  o_out;
    logic        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    fall_vote_tracker dut (.*);

    track_scoreboard sb = new();
    int  cycles = 0;
    int  hold_off = 0;      // long receiver stall, in cycles
    int  items_sent = 0;
    logic [12:0] anchor_x[4], anchor_y[4];

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if ((cycles / 300) % 3 == 0) begin
            i_out_ready <= 1'b1;    // stretch without stalls
        end else begin
            i_out_ready <= ($urandom_range(3) != 0);
        end
    end

    // driven at the falling edge; back-to-back calls may drop and raise valid
    // in the same step, so these use blocking assignments
    task automatic send(t_track_in t);
        i_in = t;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
        items_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic frame_start();
        t_track_in t;
        t = t_track_in'($urandom());
        t.mode = MODE_FRAME;
        t.shoulder_points = 48'({$urandom(), $urandom()});
        send(t);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [26:0] v);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic t_track_in detection(bit near_track);
        t_track_in t;
        int k;
        t.mode = MODE_DETECT;
        t.keypoint_count = 5'($urandom_range(17));
        if ($urandom_range(9) == 0) t.keypoint_count = 5'($urandom_range(31));
        t.shoulder_points = 48'({$urandom(), $urandom()});
        t.hip_points = 48'({$urandom(), $urandom()});
        t.keypoint_confs = $urandom();
        if ($urandom_range(1)) t.keypoint_confs |= 32'h80808080;
        t.box_w = 12'($urandom_range(4095));
        t.box_h = 12'($urandom_range(4095));
        if (near_track) begin
            // small boxes near one of a few anchors so tracks get re-matched
            k = $urandom_range(3);
            t.box_w = 12'($urandom_range(600));
            t.box_h = 12'($urandom_range(600));
            t.box_x = 12'(anchor_x[k] - (t.box_w >> 1) + $urandom_range(40) - 20);
            t.box_y = 12'(anchor_y[k] - (t.box_h >> 1) + $urandom_range(40) - 20);
        end else begin
            t.box_x = 12'($urandom_range(4095));
            t.box_y = 12'($urandom_range(4095));
        end
        return t;
    endfunction

    task automatic random_phase(int n);
        int burst;
        for (int i = 0; i < 4; i++) begin
            anchor_x[i] = 13'($urandom_range(300, 3800));
            anchor_y[i] = 13'($urandom_range(300, 3800));
        end
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                if ($urandom_range(9) == 0) frame_start();
                else send(detection($urandom_range(4) != 0));
                burst--; n--;
            end
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    endtask

    initial begin
        t_track_in t;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = CFG_MATCH_DIST_SQ;
        i_cfg_wr_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, pose vs aspect, vote climb, moving tracks
        t = '0; t.mode = MODE_DETECT;
        send(t);                                   // zero box, aspect test
        t = '1;
        send(t);                                   // all ones, pose used
        t.keypoint_confs = 32'h33333333;           // conf equal to limit: aspect
        send(t);
        t = '0; t.mode = MODE_DETECT; t.box_x = 12'd1000; t.box_y = 12'd1000;
        t.box_w = 12'd800; t.box_h = 12'd100;
        repeat (5) send(t);                        // votes climb to fallen
        t.keypoint_count = 5'd13; t.keypoint_confs = 32'hFFFFFFFF;
        t.shoulder_points = 48'h000_100_000_100;
        t.hip_points = 48'h000_900_000_900;         // sideways pose, agrees with box
        repeat (3) send(t);
        // nearby detections re-match and move one track
        t = '0; t.mode = MODE_DETECT; t.box_x = 12'd3000; t.box_y = 12'd3000;
        send(t);
        t.box_x = 12'd3100; send(t);
        t.box_x = 12'd3050; send(t);
        frame_start();
        // one track dragged along a row of nearby detections
        for (int i = 0; i < 18; i++) begin
            t = '0; t.mode = MODE_DETECT;
            t.box_x = 12'(i * 220); t.box_y = 12'd4095; t.box_w = 12'd4095;
            send(t);
        end
        drain();

        // lost-limit 0 drops everything in two frames; ident keeps counting
        write_reg(CFG_LOST_LIMIT, 27'd0);
        frame_start(); frame_start();
        write_reg(CFG_LOST_LIMIT, 27'd62);
        write_reg(CFG_MATCH_DIST_SQ, 27'd0);       // nothing matches
        write_reg(CFG_VOTE_MAX, 27'd0);
        random_phase(60);
        drain();
        write_reg(CFG_MATCH_DIST_SQ, 27'h7FFFFFF); // everything matches
        write_reg(CFG_VOTE_MAX, 27'd15);
        write_reg(CFG_FALL_VOTES, 27'd15);
        write_reg(CFG_SUSPECT_VOTES, 27'd0);
        write_reg(CFG_CONF_MIN, 27'd255);
        write_reg(CFG_ASPECT_Q8, 27'd0);
        random_phase(120);
        drain();
        write_reg(CFG_CONF_MIN, 27'd0);
        write_reg(CFG_ASPECT_Q8, 27'd1023);
        write_reg(CFG_FALL_VOTES, 27'd0);
        write_reg(CFG_LOST_LIMIT, 27'd63);         // lost saturates, never dropped
        for (int i = 0; i < 70; i++) frame_start();
        random_phase(100);
        drain();

        // long receiver stall while input keeps coming
        hold_off = 400;
        random_phase(60);
        drain();

        // several random register settings, including the reset match distance
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_MATCH_DIST_SQ,
                      (ph == 0) ? MATCH_DIST_RST : 27'($urandom_range(2000000)));
            write_reg(CFG_CONF_MIN, 27'($urandom_range(255)));
            write_reg(CFG_ASPECT_Q8, 27'($urandom_range(1023)));
            write_reg(CFG_VOTE_MAX, 27'($urandom_range(1, 15)));
            write_reg(CFG_FALL_VOTES, 27'($urandom_range(15)));
            write_reg(CFG_SUSPECT_VOTES, 27'($urandom_range(15)));
            write_reg(CFG_LOST_LIMIT, 27'($urandom_range(62)));
            random_phase(150);
            drain();
        end

        drain();
        $display("Sent %0d transactions, %0d results checked: %0d tracks opened, %0d table-full.",
                 items_sent, sb.results, sb.opened, sb.full_hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
